### sv/fmso_pkg.sv
// ----------------------------------------------------------------------------
// fmso_pkg
// Shared types, codes and constants of the FM sine oscillator.
// ----------------------------------------------------------------------------
package fmso_pkg;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NOTE,
		ST_M_U2,
		ST_F_U2,
		ST_M_POLY,
		ST_F_POLY,
		ST_M_R,
		ST_F_R,
		ST_M_SG1,
		ST_F_SG1,
		ST_M_SG2,
		ST_F_SG2,
		ST_M_F,
		ST_F_F,
		ST_M_D,
		ST_F_D,
		ST_DONE
	} state_t;

	// Item kinds carried in tuser
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_MIDI  = 2'd1;
	localparam logic [1:0] ACT_TABLE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_FM_ENABLE = 2'd0;
	localparam logic [1:0] REG_NEW_COEFF = 2'd1;
	localparam logic [1:0] REG_OLD_COEFF = 2'd2;

	// MIDI codes
	localparam logic [7:0] STATUS_NOTE_ON = 8'h91;
	localparam logic [7:0] STATUS_CTRL    = 8'hB1;
	localparam logic [6:0] KEY_OCT_DOWN   = 7'h5F;
	localparam logic [6:0] KEY_OCT_UP     = 7'h60;
	localparam logic [6:0] CTRL_MOD_GAIN  = 7'd0;

	// Field widths
	localparam int unsigned NOTE_SLOTS = 16;
	localparam int unsigned SLOT_W     = 4;
	localparam int unsigned STEP_W     = 31;
	localparam int unsigned SAMPLE_W   = 16;

	// Reset values
	localparam logic [15:0] NEW_COEFF_RST = 16'd3277;
	localparam logic [15:0] OLD_COEFF_RST = 16'd29491;
	localparam logic [3:0]  OCT_UNIT      = 4'd8;
	localparam logic [3:0]  OCT_MAX       = 4'd15;
	localparam logic [3:0]  OCT_MIN       = 4'd0;

	// Keys of the note slots, slot 0 first
	localparam logic [6:0] SLOT_KEY [NOTE_SLOTS] = '{
		7'h25, 7'h24, 7'h2a, 7'h52, 7'h28, 7'h26, 7'h2e, 7'h2c,
		7'h30, 7'h2f, 7'h2d, 7'h2b, 7'h31, 7'h37, 7'h33, 7'h35
	};

	// Q30 odd Taylor coefficients of sin(pi/2*u)
	localparam logic signed [31:0] C1 = 32'sd1686629713;
	localparam logic signed [31:0] C3 = 32'sd693598669;
	localparam logic signed [31:0] C5 = 32'sd85569306;
	localparam logic signed [31:0] C7 = 32'sd5026995;
	localparam logic signed [31:0] C9 = 32'sd172272;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} key_match_t;

	// Horner coefficient added after each multiply by u^2
	function automatic logic signed [31:0] poly_coef(input logic [1:0] k);
		logic signed [31:0] c;
		unique case (k)
			2'd0:    c = -C7;
			2'd1:    c = C5;
			2'd2:    c = -C3;
			default: c = C1;
		endcase
		return c;
	endfunction

	// Slot lookup for a note key
	function automatic key_match_t key_lookup(input logic [6:0] key);
		key_match_t m;
		m.hit  = 1'b0;
		m.slot = '0;
		for (int s = 0; s < NOTE_SLOTS; s++) begin
			if (SLOT_KEY[s] == key) begin
				m.hit  = 1'b1;
				m.slot = SLOT_W'(s);
			end
		end
		return m;
	endfunction

	// Divide by 2^30, truncating toward zero
	function automatic logic signed [63:0] trunc_q30(input logic signed [63:0] p);
		logic signed [63:0] adj;
		adj = p[63] ? (p + 64'sd1073741823) : p;
		return adj >>> 30;
	endfunction

	// Divide by 2^15, rounding half away from zero
	function automatic logic signed [63:0] round_q15(input logic signed [63:0] p);
		logic signed [63:0] mag;
		mag = -p;
		if (!p[63])
			return (p + 64'sd16384) >>> 15;
		return -((mag + 64'sd16384) >>> 15);
	endfunction

	// Sine index bits: floor(log2(depth)) within 2..16
	function automatic int sine_addr_bits(input int depth);
		int b;
		b = 2;
		for (int i = 3; i <= 16; i++) begin
			if ((1 << i) <= depth)
				b = i;
		end
		return b;
	endfunction

endpackage

### sv/fmso_ram.sv
// ----------------------------------------------------------------------------
// fmso_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmso_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### sv/fmso_mul.sv
// ----------------------------------------------------------------------------
// fmso_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fmso_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);

	// One product per cycle, registered
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

### sv/fm_sine_oscillator_midi_top.sv
// ----------------------------------------------------------------------------
// fm_sine_oscillator_midi_top
// FM sine oscillator with MIDI note, octave and modulation gain control.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A tick steps from ST_M_U2 to ST_F_R, and on
// to ST_F_D with FM enabled; a note-on for a table key passes through ST_NOTE,
// every other item leaves the sequencer idle. The length of a tick is set by
// the single shared 32x32 multiplier: the sine polynomial needs six products
// and FM four more, each product registered and then truncated, rounded or
// stored in the following cycle. The note step table is a 16-entry RAM with
// registered read data. A finished sample waits in the output register while
// the next item enters; a tick only stalls at its end if that register is still full.
module fm_sine_oscillator_midi_top #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] mod_sample, [23:16] midi_status, [30:24] midi_data1,
	// [37:31] midi_data2, [41:38] table_slot, [72:42] table_step, [79:73] zero
	input  logic [79:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] wave_sample
	output logic [15:0] m_tdata,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	import fmso_pkg::*;

	localparam int unsigned ADDR_W = sine_addr_bits(SINE_TABLE_DEPTH);

	// Input fields
	logic signed [15:0]  mod_sample;
	logic [7:0]          midi_status;
	logic [6:0]          midi_data1;
	logic [6:0]          midi_data2;
	logic [SLOT_W-1:0]   table_slot;
	logic [STEP_W-1:0]   table_step;

	assign mod_sample  = $signed(s_tdata[15:0]);
	assign midi_status = s_tdata[23:16];
	assign midi_data1  = s_tdata[30:24];
	assign midi_data2  = s_tdata[37:31];
	assign table_slot  = s_tdata[41:38];
	assign table_step  = s_tdata[72:42];

	// State and configuration
	state_t              state_q, state_d;
	logic [31:0]         phase_q;
	logic [STEP_W-1:0]   step_q;
	logic [3:0]          oct_q;
	logic [6:0]          gain_q;
	logic [15:0]         smooth_q;
	logic                fm_en_q;
	logic [15:0]         new_coeff_q;
	logic [15:0]         old_coeff_q;
	logic                out_valid_q;

	// Working registers of one tick
	logic [30:0]         u_q;
	logic [30:0]         u2_q;
	logic signed [31:0]  t_q;
	logic [1:0]          k_q;
	logic                neg_q;
	logic signed [15:0]  mod_q;
	logic [15:0]         wave_q;
	logic [31:0]         sacc_q;
	logic signed [20:0]  f_q;
	logic [15:0]         out_data_q;

	// Shared multiplier and table RAM
	logic signed [31:0]  mul_a, mul_b;
	logic signed [63:0]  prod;
	logic                ram_we, ram_re;
	logic [STEP_W-1:0]   ram_rdata;

	logic                accept;
	logic                out_load;
	key_match_t          km;

	assign accept   = s_tvalid && s_tready;
	assign km       = key_lookup(midi_data1);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	fmso_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	fmso_ram #(
		.WIDTH (STEP_W),
		.DEPTH (NOTE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (table_slot),
		.wdata (table_step),
		.re    (ram_re),
		.raddr (km.slot),
		.rdata (ram_rdata)
	);

	// Quarter-wave position of the current phase, as Q30
	logic [ADDR_W-1:0] sin_idx;
	logic [ADDR_W-3:0] sin_within;
	logic [ADDR_W-2:0] sin_pos;
	logic [30:0]       sin_u;

	assign sin_idx    = phase_q[31 -: ADDR_W];
	assign sin_within = sin_idx[ADDR_W-3:0];
	assign sin_pos    = sin_idx[ADDR_W-2]
		? ({1'b1, {(ADDR_W-2){1'b0}}} - {1'b0, sin_within})
		: {1'b0, sin_within};
	assign sin_u      = {sin_pos, {(32-ADDR_W){1'b0}}};

	// Product post-processing
	logic signed [63:0] prod_t30;
	logic signed [63:0] prod_r15;
	assign prod_t30 = trunc_q30(prod);
	assign prod_r15 = round_q15(prod);

	// Sine output: clamp, round to Q15, saturate, negate in second half
	logic [31:0] r_pos;
	logic [31:0] r_rnd;
	logic [15:0] v_sat;
	logic [15:0] wave_d;
	assign r_pos  = prod_t30[63] ? 32'd0 : prod_t30[31:0];
	assign r_rnd  = r_pos + 32'd16384;
	assign v_sat  = (r_rnd[31:15] > 17'd32767) ? 16'd32767 : r_rnd[30:15];
	assign wave_d = neg_q ? (16'd0 - v_sat) : v_sat;

	// Smoothed gain blend
	logic [33:0] sg_sum;
	logic [15:0] smooth_d;
	assign sg_sum   = {2'b00, sacc_q} + {2'b00, prod[31:0]} + 34'd16384;
	assign smooth_d = (sg_sum[33:15] > 19'd65535) ? 16'hFFFF : sg_sum[30:15];

	// Ten times the smoothed gain
	logic [19:0] sg10;
	assign sg10 = {1'b0, smooth_q, 3'b000} + {3'b000, smooth_q, 1'b0};

	// FM step, saturated to 32-bit signed
	logic signed [63:0] d_full;
	logic [31:0]        d_sat;
	assign d_full = $signed({33'd0, step_q}) + prod_r15;
	always_comb begin
		priority if (d_full > 64'sd2147483647)
			d_sat = 32'h7FFF_FFFF;
		else if (d_full < -64'sd2147483648)
			d_sat = 32'h8000_0000;
		else
			d_sat = d_full[31:0];
	end

	// Note step scaled by the octave shift
	logic [37:0]       note_up;
	logic [STEP_W-1:0] note_step;
	assign note_up = {7'd0, ram_rdata} << oct_q[2:0];
	always_comb begin
		if (oct_q[3])
			note_step = (note_up > 38'h7FFF_FFFF) ? 31'h7FFF_FFFF : note_up[30:0];
		else
			note_step = ram_rdata >> (4'd8 - oct_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == ACT_TICK)
						state_d = ST_M_U2;
					else if (s_tuser == ACT_MIDI && midi_status == STATUS_NOTE_ON && km.hit)
						state_d = ST_NOTE;
				end
			end
			ST_NOTE:   state_d = ST_IDLE;
			ST_M_U2:   state_d = ST_F_U2;
			ST_F_U2:   state_d = ST_M_POLY;
			ST_M_POLY: state_d = ST_F_POLY;
			ST_F_POLY: state_d = (k_q == 2'd3) ? ST_M_R : ST_M_POLY;
			ST_M_R:    state_d = ST_F_R;
			ST_F_R:    state_d = fm_en_q ? ST_M_SG1 : ST_DONE;
			ST_M_SG1:  state_d = ST_F_SG1;
			ST_F_SG1:  state_d = ST_M_SG2;
			ST_M_SG2:  state_d = ST_F_SG2;
			ST_F_SG2:  state_d = ST_M_F;
			ST_M_F:    state_d = ST_F_F;
			ST_F_F:    state_d = ST_M_D;
			ST_M_D:    state_d = ST_F_D;
			ST_F_D:    state_d = ST_DONE;
			ST_DONE:   state_d = out_load ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// State outputs: handshake, multiplier operands, table access
	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_we   = accept && (s_tuser == ACT_TABLE);
				ram_re   = accept && (s_tuser == ACT_MIDI)
					&& (midi_status == STATUS_NOTE_ON) && km.hit;
			end
			ST_M_U2: begin
				mul_a = $signed({1'b0, u_q});
				mul_b = $signed({1'b0, u_q});
			end
			ST_M_POLY: begin
				mul_a = t_q;
				mul_b = $signed({1'b0, u2_q});
			end
			ST_M_R: begin
				mul_a = t_q;
				mul_b = $signed({1'b0, u_q});
			end
			ST_M_SG1: begin
				mul_a = $signed({16'd0, new_coeff_q});
				mul_b = $signed({17'd0, gain_q, 8'd0});
			end
			ST_M_SG2: begin
				mul_a = $signed({16'd0, old_coeff_q});
				mul_b = $signed({16'd0, smooth_q});
			end
			ST_M_F: begin
				mul_a = $signed({12'd0, sg10});
				mul_b = {{16{mod_q[15]}}, mod_q};
			end
			ST_M_D: begin
				mul_a = $signed({1'b0, step_q});
				mul_b = {{11{f_q[20]}}, f_q};
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control state, oscillator state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			step_q      <= '0;
			oct_q       <= OCT_UNIT;
			gain_q      <= '0;
			smooth_q    <= '0;
			fm_en_q     <= 1'b0;
			new_coeff_q <= NEW_COEFF_RST;
			old_coeff_q <= OLD_COEFF_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FM_ENABLE: fm_en_q     <= cfg_wdata[0];
					REG_NEW_COEFF: new_coeff_q <= cfg_wdata;
					REG_OLD_COEFF: old_coeff_q <= cfg_wdata;
					default:       ;
				endcase
			end

			// MIDI messages
			if (accept && s_tuser == ACT_MIDI) begin
				if (midi_status == STATUS_NOTE_ON && !km.hit) begin
					if (midi_data1 == KEY_OCT_DOWN && oct_q > OCT_MIN)
						oct_q <= oct_q - 4'd1;
					else if (midi_data1 == KEY_OCT_UP && oct_q < OCT_MAX)
						oct_q <= oct_q + 4'd1;
				end else if (midi_status == STATUS_CTRL && midi_data1 == CTRL_MOD_GAIN) begin
					gain_q <= midi_data2;
				end
			end

			if (state_q == ST_NOTE)
				step_q <= note_step;

			// phase advance
			if (state_q == ST_F_R && !fm_en_q)
				phase_q <= phase_q + {1'b0, step_q};
			if (state_q == ST_F_D)
				phase_q <= phase_q + d_sat;

			if (state_q == ST_F_SG2)
				smooth_q <= smooth_d;

			// result register
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers of the sine and FM sequence
	always_ff @(posedge clk) begin
		if (accept && s_tuser == ACT_TICK) begin
			u_q   <= sin_u;
			neg_q <= phase_q[31];
			t_q   <= C9;
			k_q   <= 2'd0;
			mod_q <= mod_sample;
		end
		if (state_q == ST_F_U2)
			u2_q <= prod_t30[30:0];
		if (state_q == ST_F_POLY) begin
			t_q <= poly_coef(k_q) + $signed(prod_t30[31:0]);
			k_q <= k_q + 2'd1;
		end
		if (state_q == ST_F_R)
			wave_q <= wave_d;
		if (state_q == ST_F_SG1)
			sacc_q <= prod[31:0];
		if (state_q == ST_F_F)
			f_q <= prod_r15[20:0];
		if (out_load)
			out_data_q <= wave_q;
	end

endmodule

### sv/fmso_checker.sv
// ----------------------------------------------------------------------------
// fmso_checker
// Port-level checks of the FM sine oscillator, bound to its top level.
// ----------------------------------------------------------------------------
module fmso_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	import fmso_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No result in the cycle after a reset edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// A tick keeps the block busy in the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_TICK |=> !s_tready)
		else $error("input taken while a tick is in progress");

	// Items other than ticks create no result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != ACT_TICK && !m_tvalid |=> !m_tvalid)
		else $error("result from an item that is not a tick");

	// Saturated sine never reaches full negative scale
	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("sine sample out of range");

endmodule

bind fm_sine_oscillator_midi_top fmso_checker u_fmso_checker (.*);
